// ===== rtl/epdm_pkg.sv =====
// ----------------------------------------------------------------------------
// epdm_pkg
// Shared widths, constants and reciprocal tables for the echo peak distance
// meter: window counter, distance output and the time to centimetre divider.
// ----------------------------------------------------------------------------
package epdm_pkg;

  // window counter and configuration register
  localparam int WIN_BITS  = 12;
  localparam int DIST_BITS = 9;

  typedef logic [WIN_BITS-1:0]  win_t;
  typedef logic [DIST_BITS-1:0] dist_t;

  localparam win_t WIN_RESET = win_t'(1000);

  // divider operand: any time below the far limit fits in 16 bits
  localparam int MUL_BITS   = 16;
  localparam int RECIP_BITS = 19;
  localparam int DIV_SHIFT  = 24;
  localparam int PROD_BITS  = MUL_BITS + RECIP_BITS;

  typedef logic [MUL_BITS-1:0]   mul_t;
  typedef logic [RECIP_BITS-1:0] recip_t;
  typedef logic [PROD_BITS-1:0]  prod_t;

  // range limits, upper bound exclusive
  localparam mul_t LIM_40  = mul_t'(600);
  localparam mul_t LIM_60  = mul_t'(1200);
  localparam mul_t LIM_90  = mul_t'(2800);
  localparam mul_t LIM_110 = mul_t'(7200);
  localparam mul_t LIM_125 = mul_t'(20000);
  localparam int unsigned TIME_LIMIT = 35000;

  // rounded-up reciprocals, exact for every 16-bit dividend at this shift
  localparam longint unsigned DIV_SCALE = 64'd1 << DIV_SHIFT;
  localparam recip_t RECIP_40  = recip_t'((DIV_SCALE + 64'd39)  / 64'd40);
  localparam recip_t RECIP_60  = recip_t'((DIV_SCALE + 64'd59)  / 64'd60);
  localparam recip_t RECIP_90  = recip_t'((DIV_SCALE + 64'd89)  / 64'd90);
  localparam recip_t RECIP_110 = recip_t'((DIV_SCALE + 64'd109) / 64'd110);
  localparam recip_t RECIP_125 = recip_t'((DIV_SCALE + 64'd124) / 64'd125);
  localparam recip_t RECIP_135 = recip_t'((DIV_SCALE + 64'd134) / 64'd135);

endpackage

// ===== rtl/epdm_divider.sv =====
// ----------------------------------------------------------------------------
// epdm_divider
// Converts a peak time into centimetres: range select, one multiply by a
// reciprocal and a shift, with the result and too-far flag registered.
// ----------------------------------------------------------------------------
module epdm_divider
  import epdm_pkg::*;
#(
  parameter int STAMP_BITS = 16
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [STAMP_BITS-1:0] stamp_in,
  output dist_t                 distance_cm,
  output logic                  too_far
);

  logic   far;
  mul_t   t_low;
  recip_t recip;
  prod_t  product;
  dist_t  quot;
  dist_t  dist_next;

  // out of range check on the full stamp width
  assign far   = (stamp_in >= STAMP_BITS'(TIME_LIMIT));
  assign t_low = stamp_in[MUL_BITS-1:0];

  // reciprocal by range
  always_comb begin
    if (t_low < LIM_40) begin
      recip = RECIP_40;
    end else if (t_low < LIM_60) begin
      recip = RECIP_60;
    end else if (t_low < LIM_90) begin
      recip = RECIP_90;
    end else if (t_low < LIM_110) begin
      recip = RECIP_110;
    end else if (t_low < LIM_125) begin
      recip = RECIP_125;
    end else begin
      recip = RECIP_135;
    end
  end

  // multiply and take the integer part
  assign product   = prod_t'(t_low) * prod_t'(recip);
  assign quot      = product[DIV_SHIFT +: DIST_BITS];
  assign dist_next = far ? '0 : quot;

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      distance_cm <= dist_next;
      too_far     <= (dist_next == '0);
    end
  end

endmodule

// ===== rtl/echo_peak_distance_meter_core.sv =====
// ----------------------------------------------------------------------------
// echo_peak_distance_meter_core
// Finds a rising echo pair, scans a window for the peak sample and emits the
// distance of that peak in centimetres.
// ----------------------------------------------------------------------------
// result path: the peak time register loads when the last window item is accepted,
//   then the divider result register loads once the output can take it
// throughput: one item per cycle; the input stalls only when a result is held
//   in both stages and the output is stalled
// reset: synchronous, clears phase, pair and peak state, sets window length 1000
module echo_peak_distance_meter_core
  import epdm_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int STAMP_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_wr_en,
  input  win_t                   cfg_wr_data,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   start_req,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [STAMP_BITS-1:0]  timestamp,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output dist_t                  distance_cm,
  output logic                   too_far
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PAIR = 2'd1;
  localparam logic [1:0] PH_WIN  = 2'd2;

  win_t                   window_length;
  logic [1:0]             phase, phase_next;
  logic [SAMPLE_BITS-1:0] pair_first, pair_first_next;
  logic                   pair_half, pair_half_next;
  logic [SAMPLE_BITS-1:0] peak_value, peak_value_next;
  logic [STAMP_BITS-1:0]  peak_time, peak_time_next;
  win_t                   window_count, window_count_next;
  logic                   emit;

  logic                   s1_valid;
  logic [STAMP_BITS-1:0]  s1_time;
  logic                   out_ready;
  logic                   s1_adv;
  logic                   in_acc;

  // handshake between stages
  assign out_ready = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_length <= cfg_wr_data;
    end
  end

  // per-item state update
  always_comb begin
    phase_next        = phase;
    pair_first_next   = pair_first;
    pair_half_next    = pair_half;
    peak_value_next   = peak_value;
    peak_time_next    = peak_time;
    window_count_next = window_count;
    emit              = 1'b0;
    if (start_req) begin
      phase_next      = PH_PAIR;
      pair_first_next = sample;
      pair_half_next  = 1'b1;
    end else begin
      unique case (phase)
        PH_PAIR: begin
          if (!pair_half) begin
            pair_first_next = sample;
            pair_half_next  = 1'b1;
          end else if (sample >= pair_first) begin
            pair_half_next    = 1'b0;
            phase_next        = PH_WIN;
            peak_value_next   = '0;
            window_count_next = '0;
          end else begin
            pair_half_next = 1'b0;
          end
        end
        PH_WIN: begin
          if (sample > peak_value) begin
            peak_value_next = sample;
            peak_time_next  = timestamp;
          end
          window_count_next = window_count + win_t'(1);
          if (window_count_next == window_length) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
          end
        end
        default: begin
          // idle and the unused code ignore items without start
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pair_first   <= '0;
      pair_half    <= 1'b0;
      peak_value   <= '0;
      peak_time    <= '0;
      window_count <= '0;
    end else if (in_acc) begin
      phase        <= phase_next;
      pair_first   <= pair_first_next;
      pair_half    <= pair_half_next;
      peak_value   <= peak_value_next;
      peak_time    <= peak_time_next;
      window_count <= window_count_next;
    end
  end

  // peak time stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && emit) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      s1_time <= peak_time_next;
    end
  end

  // distance conversion and result register
  epdm_divider #(
    .STAMP_BITS (STAMP_BITS)
  ) u_divider (
    .clk         (clk),
    .load        (s1_adv),
    .stamp_in    (s1_time),
    .distance_cm (distance_cm),
    .too_far     (too_far)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // flag agrees with the distance
  a_too_far: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (too_far == (distance_cm == '0)))
    else $error("too_far does not match distance_cm");

  // distance never beyond the largest range
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_cm <= dist_t'(259)))
    else $error("distance_cm out of range");

  // a new result only comes from the peak time stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a pending peak time");

  // input held only while the peak time stage is blocked
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the echo peak distance meter core. Measurement
// sequences (start, echo pairs, peak window) go through a bursty driver, a
// monitor predicts each distance result on input acceptance and checks the
// results in order against the core while the output side stalls in patterns.
// ----------------------------------------------------------------------------
module testbench;
  import epdm_pkg::*;

  localparam int SMP_W = 12;
  localparam int STAMP_W = 16;
  localparam int SMP_MAX = (1 << SMP_W) - 1;
  localparam int STAMP_MAX = (1 << STAMP_W) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int FINAL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 300;

  // time bands: upper bound exclusive and divisor of each band
  localparam int unsigned BAND_TOP [6] = '{600, 1200, 2800, 7200, 20000, 35000};
  localparam int unsigned BAND_DIV [6] = '{40, 60, 90, 110, 125, 135};

  typedef enum logic [1:0] {MEAS_IDLE, MEAS_PAIR, MEAS_WINDOW} meas_phase_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  typedef struct {
    logic               start;
    logic [SMP_W-1:0]   smp;
    logic [STAMP_W-1:0] stamp;
  } echo_item_t;

  typedef struct {
    dist_t cm;
    logic  far;
  } distance_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  win_t cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic start_req = 1'b0;
  logic [SMP_W-1:0] sample = '0;
  logic [STAMP_W-1:0] timestamp = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dist_t distance_cm;
  logic too_far;

  echo_item_t echo_pend_q[$];
  distance_t dist_exp_q[$];
  echo_item_t drv_item;
  int items_queued = 0;
  int items_taken = 0;
  int meas_items = 0;
  int err_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int stall_timer = 0;
  logic [2:0] stall_tick = '0;
  stall_mode_t stall_mode = STALL_NONE;

  // predictor state
  meas_phase_t meas_phase = MEAS_IDLE;
  logic [SMP_W-1:0] pair_ref = '0;
  logic pair_second = 1'b0;
  logic [SMP_W-1:0] peak_val = '0;
  logic [STAMP_W-1:0] peak_stamp = '0;
  win_t win_cnt = '0;
  win_t win_len_model = WIN_RESET;

  echo_peak_distance_meter_core #(
    .SAMPLE_BITS(SMP_W),
    .STAMP_BITS (STAMP_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_req  (start_req),
    .sample     (sample),
    .timestamp  (timestamp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance_cm(distance_cm),
    .too_far    (too_far)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // peak time to centimetres, zero beyond the last band
  function automatic dist_t stamp_to_cm(input logic [STAMP_W-1:0] t);
    int unsigned tv;
    tv = 32'(t);
    for (int b = 0; b < 6; b++) begin
      if (tv < BAND_TOP[b]) return dist_t'(tv / BAND_DIV[b]);
    end
    return '0;
  endfunction

  // advance the measurement state by one accepted item
  task automatic take_echo(input logic start, input logic [SMP_W-1:0] s,
                           input logic [STAMP_W-1:0] t);
    distance_t res;
    items_taken++;
    if (start) begin
      meas_phase = MEAS_PAIR;
      pair_ref = s;
      pair_second = 1'b1;
    end else if (meas_phase == MEAS_PAIR) begin
      if (!pair_second) begin
        pair_ref = s;
        pair_second = 1'b1;
      end else if (s >= pair_ref) begin
        pair_second = 1'b0;
        meas_phase = MEAS_WINDOW;
        peak_val = '0;
        win_cnt = '0;
      end else begin
        pair_second = 1'b0;
      end
    end else if (meas_phase == MEAS_WINDOW) begin
      if (s > peak_val) begin
        peak_val = s;
        peak_stamp = t;
      end
      win_cnt = win_cnt + 1'b1;
      if (win_cnt == win_len_model) begin
        meas_phase = MEAS_IDLE;
        res.cm = stamp_to_cm(peak_stamp);
        res.far = (res.cm == '0);
        dist_exp_q.push_back(res);
      end
    end
  endtask

  task automatic flag_error(input string what, input int want, input int got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // compare one result item with the oldest prediction
  task automatic check_distance();
    distance_t want;
    if (dist_exp_q.size() == 0) begin
      flag_error("unexpected result distance_cm", -1, int'(distance_cm));
    end else begin
      want = dist_exp_q.pop_front();
      if (distance_cm !== want.cm)
        flag_error("distance_cm", int'(want.cm), int'(distance_cm));
      if (too_far !== want.far) flag_error("too_far", int'(want.far), int'(too_far));
    end
  endtask

  // monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) take_echo(start_req, sample, timestamp);
      if (out_valid && !out_stall) check_distance();
    end
  end

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= $urandom_range(1, 30);
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (echo_pend_q.size() != 0) begin
        drv_item = echo_pend_q.pop_front();
        in_valid <= 1'b1;
        start_req <= drv_item.start;
        sample <= drv_item.smp;
        timestamp <= drv_item.stamp;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, mode chosen at random whenever the stall timer runs out
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= STALL_NONE;
      stall_timer <= 64;
      stall_tick <= '0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_timer == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_timer <= $urandom_range(32, 300);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= stall_tick[2];
      endcase
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_item(input logic start, input int s, input int t);
    echo_item_t it;
    it.start = start;
    it.smp = s[SMP_W-1:0];
    it.stamp = t[STAMP_W-1:0];
    echo_pend_q.push_back(it);
    items_queued++;
  endtask

  // idle items with no start, ignored by an idle core
  task automatic queue_noise(input int n);
    for (int k = 0; k < n; k++) queue_item(1'b0, $urandom_range(0, SMP_MAX), $urandom);
  endtask

  // timer value from a randomly chosen distance band
  function automatic int pick_stamp();
    int band;
    band = $urandom_range(0, 7);
    case (band)
      0: return $urandom_range(0, 599);
      1: return $urandom_range(600, 1199);
      2: return $urandom_range(1200, 2799);
      3: return $urandom_range(2800, 7199);
      4: return $urandom_range(7200, 19999);
      5: return $urandom_range(20000, 34999);
      6: return $urandom_range(35000, STAMP_MAX);
      default: return $urandom_range(0, STAMP_MAX);
    endcase
  endfunction

  // start, falling pairs, rising pair and a window of span samples;
  // an abandoned one stops early and must be followed by another start
  task automatic queue_measurement(input int span, input bit abandon);
    int falls, pairs, first, second, n, mode, ts;
    bit rose;
    falls = $urandom_range(0, 3);
    pairs = 0;
    rose = 0;
    first = $urandom_range(0, SMP_MAX);
    queue_item(1'b1, first, $urandom);
    meas_items++;
    if (abandon && $urandom_range(0, 2) == 0) return;
    do begin
      if (pairs != 0) begin
        first = $urandom_range(0, SMP_MAX);
        queue_item(1'b0, first, $urandom);
      end
      if (pairs < falls && first != 0) begin
        second = $urandom_range(0, first - 1);
      end else begin
        second = $urandom_range(first, SMP_MAX);
        rose = 1;
      end
      queue_item(1'b0, second, $urandom);
      pairs++;
      meas_items += (pairs == 1) ? 1 : 2;
    end while (!rose);
    n = abandon ? $urandom_range(0, span - 1) : span;
    mode = $urandom_range(0, 7);
    ts = pick_stamp();
    for (int k = 0; k < n; k++) begin
      case (mode)
        0: queue_item(1'b0, 0, ts);
        1: queue_item(1'b0, $urandom_range(0, 3), ts);
        default: queue_item(1'b0, $urandom_range(0, SMP_MAX), ts);
      endcase
      ts = ($urandom_range(0, 9) == 0) ? pick_stamp() : ts + $urandom_range(0, 40);
    end
    meas_items += n;
  endtask

  // wait until every item is taken and every result has come
  task automatic wait_drained();
    while (items_taken != items_queued || dist_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input win_t len);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    win_len_model = len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(1, 4);
    if (r < 8) return $urandom_range(5, 20);
    if (r == 8) return $urandom_range(21, 100);
    return $urandom_range(101, 300);
  endfunction

  // stimulus
  initial begin
    int boundary [9];
    int wlen, phase_end, waited;
    boundary = '{599, 600, 1200, 2800, 7199, 7200, 20000, 34999, 35000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window length: ignored items, falling then rising pair, all-zero window
    queue_noise(2);
    queue_item(1'b1, 100, 7);
    queue_item(1'b0, 50, 8);
    queue_item(1'b0, 10, 9);
    queue_item(1'b0, 10, 10);
    for (int k = 0; k < 1000; k++) queue_item(1'b0, 0, $urandom);
    wait_drained();

    // one-sample windows across the band limits, then a zero window keeping the old time
    write_window(win_t'(1));
    foreach (boundary[i])
      begin
        queue_item(1'b1, 0, 0);
        queue_item(1'b0, 0, 0);
        queue_item(1'b0, (i == 0) ? SMP_MAX : $urandom_range(1, SMP_MAX), boundary[i]);
      end
    queue_item(1'b1, SMP_MAX, 0);
    queue_item(1'b0, SMP_MAX, 0);
    queue_item(1'b0, 0, 123);
    wait_drained();

    // random phases with mostly short windows
    meas_items = 0;
    while (meas_items < RANDOM_ITEMS) begin
      wlen = pick_window();
      write_window(win_t'(wlen));
      phase_end = meas_items + $urandom_range(100, 200);
      if ($urandom_range(0, 1) == 0) queue_noise($urandom_range(1, 3));
      while (meas_items < phase_end) begin
        if ($urandom_range(0, 5) == 0) queue_measurement(wlen, 1'b1);
        queue_measurement(wlen, 1'b0);
        if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 4));
      end
      wait_drained();
    end

    // final drain with a bound, leftovers count as failures
    waited = 0;
    while ((items_taken != items_queued || dist_exp_q.size() != 0) && waited < FINAL_LIMIT)
      begin
        @(posedge clk);
        waited++;
      end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (dist_exp_q.size() != 0) flag_error("results still awaited", 0, dist_exp_q.size());
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
